@@ design/tpsd_pkg.sv @@
// package for the touch pad swipe detector: sizes, codes and reset values
package tpsd_pkg;

  // pads in the row, and the width of the pad level and change fields
  localparam int PadCount     = 8;
  localparam int PadInputBits = 8;
  localparam int PadIdxW      = $clog2(PadCount);

  localparam int TimeW   = 32;
  localparam int GapW    = 16;
  localparam int ResultW = 2;
  localparam int CfgIdxW = 1;

  localparam logic [GapW-1:0] MinGapReset = GapW'(40);
  localparam logic [GapW-1:0] MaxGapReset = GapW'(300);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMinGap = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxGap = CfgIdxW'(1);

  // swipe result codes
  localparam logic [ResultW-1:0] ResNone    = ResultW'(0);
  localparam logic [ResultW-1:0] ResForward = ResultW'(1);
  localparam logic [ResultW-1:0] ResBack    = ResultW'(2);

  // pad indexes of interest
  localparam logic [PadIdxW-1:0] FirstPad     = PadIdxW'(0);
  localparam logic [PadIdxW-1:0] SecondPad    = PadIdxW'(1);
  localparam logic [PadIdxW-1:0] LastPad      = PadIdxW'(PadCount - 1);
  localparam logic [PadIdxW-1:0] NextLastPad  = PadIdxW'(PadCount - 2);

  typedef enum logic [1:0] {
    DirIdle    = 2'd0,
    DirForward = 2'd1,
    DirBack    = 2'd2
  } dir_e;

endpackage

@@ design/touch_pad_swipe_detector_top.sv @@
// touch pad swipe detector: input register, swipe tracker and result register
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i in_ready_o pad_pressed_i            | in
//          | pad_changed_i now_ms_i                         |
//  out     | out_valid_o out_ready_i swipe_result_o         | out
//  cfg     | cfg_we_i cfg_addr_i cfg_wdata_i (write only)   | in
//
// one transaction per cycle sustained while the output is not stalled; a scan
// tick passes through the input register, then the result register
// the tracker state is updated from the input register in the same cycle the
// result is loaded, so the next tick sees it without a bubble
// reset clears tracking state, gap limits to 40 and 300 ms, and both valids
// a stall on the output holds the result and the tick in the input register;
// in_ready_o falls only when both registers are full and the output is stalled
module touch_pad_swipe_detector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tpsd_pkg::PadInputBits-1:0] pad_pressed_i,
  input  logic [tpsd_pkg::PadInputBits-1:0] pad_changed_i,
  input  logic [tpsd_pkg::TimeW-1:0]    now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tpsd_pkg::ResultW-1:0]  swipe_result_o,
  input  logic                          cfg_we_i,
  input  logic [tpsd_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [tpsd_pkg::GapW-1:0]     cfg_wdata_i
);
  import tpsd_pkg::*;

  // configuration
  logic [GapW-1:0] min_gap_q, max_gap_q;

  // input register
  logic                    s1_valid_q;
  logic [PadInputBits-1:0] pressed_q, changed_q;
  logic [TimeW-1:0]        now_q;

  // tracker state
  dir_e               dir_q, dir_d;
  logic [PadIdxW-1:0] exp_q, exp_d;
  logic [TimeW-1:0]   last_time_q, last_time_d;

  // result register
  logic               out_valid_q;
  logic [ResultW-1:0] res_q, res_d;

  logic s1_fire, in_fire;

  // pad vectors sized to the pad row; pads past the input width read as zero
  logic [PadCount-1:0] pressed_v, changed_v;
  logic [PadIdxW-1:0]  prev_pad;
  logic [TimeW-1:0]    gap;
  logic                gap_ok;
  logic                prev_released, exp_pressed, exp_fresh;
  logic                first_fresh, last_fresh, at_end;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_valid_o    = out_valid_q;
  assign swipe_result_o = res_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= MinGapReset;
      max_gap_q <= MaxGapReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgMinGap: min_gap_q <= cfg_wdata_i;
        CfgMaxGap: max_gap_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pressed_q <= pad_pressed_i;
      changed_q <= pad_changed_i;
      now_q     <= now_ms_i;
    end
  end

  always_comb begin
    pressed_v = '0;
    changed_v = '0;
    for (int i = 0; i < PadCount; i++) begin
      if (i < PadInputBits) begin
        pressed_v[i] = pressed_q[i];
        changed_v[i] = changed_q[i];
      end
    end
  end

  // decode of the current tick against the tracked swipe
  assign prev_pad      = (dir_q == DirForward) ? exp_q - PadIdxW'(1) : exp_q + PadIdxW'(1);
  assign prev_released = changed_v[prev_pad] && !pressed_v[prev_pad];
  assign exp_pressed   = pressed_v[exp_q];
  assign exp_fresh     = changed_v[exp_q] && pressed_v[exp_q];
  assign first_fresh   = changed_v[FirstPad] && pressed_v[FirstPad];
  assign last_fresh    = changed_v[LastPad] && pressed_v[LastPad];
  assign at_end        = (exp_q == FirstPad) || (exp_q >= LastPad);

  // modulo 2^32 gap, open interval test
  assign gap    = now_q - last_time_q;
  assign gap_ok = (gap > TimeW'(min_gap_q)) && (gap < TimeW'(max_gap_q));

  // next state
  always_comb begin
    dir_d       = dir_q;
    exp_d       = exp_q;
    last_time_d = last_time_q;
    case (dir_q)
      DirForward, DirBack: begin
        if (prev_released) begin
          // early release only ends the swipe if the next pad is not held
          if (!exp_pressed) begin
            dir_d = DirIdle;
          end
        end else if (exp_fresh) begin
          if (gap_ok) begin
            last_time_d = now_q;
            if (at_end) begin
              dir_d = DirIdle;
            end else if (dir_q == DirForward) begin
              exp_d = exp_q + PadIdxW'(1);
            end else begin
              exp_d = exp_q - PadIdxW'(1);
            end
          end else begin
            dir_d = DirIdle;
          end
        end
      end
      default: begin
        // idle: first pad wins when both ends are pressed together
        dir_d = DirIdle;
        if (first_fresh) begin
          dir_d       = DirForward;
          last_time_d = now_q;
        end else if (last_fresh) begin
          dir_d       = DirBack;
          last_time_d = now_q;
        end
        exp_d = (dir_d == DirBack) ? NextLastPad : SecondPad;
      end
    endcase
  end

  // result of the current tick
  always_comb begin
    res_d = ResNone;
    case (dir_q)
      DirForward: if (!prev_released && exp_fresh && gap_ok && at_end) res_d = ResForward;
      DirBack:    if (!prev_released && exp_fresh && gap_ok && at_end) res_d = ResBack;
      default:    res_d = ResNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= DirIdle;
      exp_q       <= '0;
      last_time_q <= '0;
    end else if (s1_fire) begin
      dir_q       <= dir_d;
      exp_q       <= exp_d;
      last_time_q <= last_time_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  // checks
  a_res_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q == ResNone || res_q == ResForward || res_q == ResBack))
    else $error("swipe result code out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && res_d != ResNone |=> dir_q == DirIdle)
    else $error("tracker not idle after reporting a swipe");

  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q != DirIdle |-> exp_q <= LastPad)
    else $error("expected pad outside the pad row");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled while a register is free");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(dir_q) && $stable(exp_q) && $stable(last_time_q))
    else $error("tracker state moved without a tick");

endmodule
